// ----- rtl/lpcd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types and constants for the length-prefixed code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcd_pkg;

  localparam int CHAR_W         = 8;  // table character
  localparam int LEN_W          = 3;  // code length / length field value
  localparam int CODE_W         = 7;  // bit accumulator, widest code
  localparam int LEN_FIELD_BITS = 3;  // bits in a segment length field
  localparam int QUEUE_DEPTH    = 2;  // command queue between front and back

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOM  = 1'b1;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_BIT    = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_EOM    = 2'd2
  } op_t;

  typedef enum logic {
    DEC_LENGTH = 1'b0,
    DEC_CODE   = 1'b1
  } dec_state_t;

  // One unit of work for the back end: a table write, a lookup or an
  // end-of-message marker. hit says the looked-up slot holds header data.
  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] data;
    logic              hit;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/length_prefixed_code_decoder.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_code_decoder
// Decodes a length-prefixed serial code stream against a header-loaded table.
// ----------------------------------------------------------------------------
// Path: the completing bit's command goes through the queue, s1 and output stage.
// Throughput: one item per cycle; the table RAM takes one write or one read
//   per cycle; input stalls only once two commands wait behind a stalled result.
// Reset: synchronous, clears the fill pointer, bit decoder, queue and output
//   stage. The table RAM is not swept; a start item or reset retires its
//   contents through the fill pointer, so no clearing pass is needed.
`default_nettype none

module length_prefixed_code_decoder #(
  parameter int MAX_CODE_LEN = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] header_char, [8] code_bit
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] decoded_char
  output logic             out_tuser   // [0] kind
);

  logic            in_accept;
  logic            cmd_valid;
  lpcd_pkg::cmd_t  cmd;
  logic            q_full;
  logic            q_pop;
  logic            q_head_valid;
  lpcd_pkg::cmd_t  q_head_cmd;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  lpcd_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_req_type    (in_tuser),
    .in_header_char (in_tdata[7:0]),
    .in_code_bit    (in_tdata[8]),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd)
  );

  lpcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  lpcd_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/lpcd_ram.sv -----
// ----------------------------------------------------------------------------
// lpcd_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpcd_front.sv -----
// ----------------------------------------------------------------------------
// lpcd_front
// Classifies accepted items, tracks the table fill pointer and the bit
// decoder, and issues table writes, lookups and end-of-message commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_front #(
  parameter int MAX_CODE_LEN = 7
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_accept,
  input  wire logic [1:0]                          in_req_type,
  input  wire logic [lpcd_pkg::CHAR_W-1:0]         in_header_char,
  input  wire logic                                in_code_bit,
  output logic                                     cmd_valid,
  output lpcd_pkg::cmd_t                           cmd
);

  localparam int MW = MAX_CODE_LEN;
  localparam int CW = lpcd_pkg::CODE_W;
  localparam int LW = lpcd_pkg::LEN_W;
  localparam logic [LW-1:0] MAX_LEN     = LW'(MAX_CODE_LEN);
  localparam logic [LW-1:0] FIELD_COUNT = LW'(lpcd_pkg::LEN_FIELD_BITS);

  logic [LW-1:0]          fill_len_r, fill_len_nxt;
  logic [MW-1:0]          fill_idx_r, fill_idx_nxt;
  lpcd_pkg::dec_state_t   state_r, state_nxt;
  logic [LW-1:0]          seg_len_r, seg_len_nxt;
  logic [LW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          acc_r, acc_nxt;

  logic [MW-1:0]          limit;
  logic [MW-1:0]          idx_tmp;
  logic [CW-1:0]          acc_shift;
  logic [LW-1:0]          cnt_inc;
  logic [CW-1:0]          seg_ones;
  lpcd_pkg::req_t         req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_len_r <= LW'(1);
      fill_idx_r <= '0;
      state_r    <= lpcd_pkg::DEC_LENGTH;
      seg_len_r  <= '0;
      cnt_r      <= '0;
      acc_r      <= '0;
    end else begin
      fill_len_r <= fill_len_nxt;
      fill_idx_r <= fill_idx_nxt;
      state_r    <= state_nxt;
      seg_len_r  <= seg_len_nxt;
      cnt_r      <= cnt_nxt;
      acc_r      <= acc_nxt;
    end
  end

  always_comb begin
    fill_len_nxt = fill_len_r;
    fill_idx_nxt = fill_idx_r;
    state_nxt    = state_r;
    seg_len_nxt  = seg_len_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    cmd_valid    = 1'b0;
    cmd          = '0;
    req          = lpcd_pkg::req_t'(in_req_type);
    // slots available at the current fill length
    limit        = ~({MW{1'b1}} << fill_len_r);
    idx_tmp      = fill_idx_r;
    acc_shift    = {acc_r[CW-2:0], in_code_bit};
    cnt_inc      = cnt_r + LW'(1);
    seg_ones     = ~({CW{1'b1}} << seg_len_r);

    if (in_accept) begin
      unique case (req)
        lpcd_pkg::REQ_START: begin
          // old table contents go stale through the fill pointer
          fill_len_nxt = LW'(1);
          fill_idx_nxt = '0;
          state_nxt    = lpcd_pkg::DEC_LENGTH;
          seg_len_nxt  = '0;
          cnt_nxt      = '0;
          acc_nxt      = '0;
        end
        lpcd_pkg::REQ_HEADER: begin
          if (fill_idx_r < limit) begin
            cmd_valid = 1'b1;
            cmd.op    = lpcd_pkg::OP_WRITE;
            cmd.len   = fill_len_r;
            cmd.code  = CW'(fill_idx_r);
            cmd.data  = in_header_char;
            idx_tmp   = fill_idx_r + MW'(1);
          end
          fill_idx_nxt = idx_tmp;
          if (idx_tmp >= limit && fill_len_r < MAX_LEN) begin
            fill_len_nxt = fill_len_r + LW'(1);
            fill_idx_nxt = '0;
          end
        end
        lpcd_pkg::REQ_BIT: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          unique case (state_r)
            lpcd_pkg::DEC_LENGTH: begin
              if (cnt_inc == FIELD_COUNT) begin
                acc_nxt = '0;
                cnt_nxt = '0;
                if (acc_shift[LW-1:0] == '0) begin
                  cmd_valid = 1'b1;
                  cmd.op    = lpcd_pkg::OP_EOM;
                end else begin
                  seg_len_nxt = acc_shift[LW-1:0];
                  state_nxt   = lpcd_pkg::DEC_CODE;
                end
              end
            end
            lpcd_pkg::DEC_CODE: begin
              if (cnt_inc == seg_len_r) begin
                acc_nxt = '0;
                cnt_nxt = '0;
                if (acc_shift == seg_ones) begin
                  // all-ones code closes the segment
                  state_nxt = lpcd_pkg::DEC_LENGTH;
                end else begin
                  cmd_valid = 1'b1;
                  cmd.op    = lpcd_pkg::OP_LOOKUP;
                  cmd.len   = seg_len_r;
                  cmd.code  = acc_shift;
                  // slot was written since the last start
                  cmd.hit   = (seg_len_r < fill_len_r) ||
                              (seg_len_r == fill_len_r && acc_shift < CW'(fill_idx_r));
                end
              end
            end
          endcase
        end
        lpcd_pkg::REQ_NOP: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpcd_queue.sv -----
// ----------------------------------------------------------------------------
// lpcd_queue
// Short command queue that decouples the front end from the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lpcd_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output lpcd_pkg::cmd_t      head_cmd
);

  localparam int DEPTH = lpcd_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  lpcd_pkg::cmd_t   mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full       = (count_r == CNTW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt  = pop  ? ptr_inc(rptr_r) : rptr_r;
    count_nxt = count_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpcd_back.sv -----
// ----------------------------------------------------------------------------
// lpcd_back
// Executes queued commands against the code table RAM and drives the
// result stream through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_back #(
  parameter int MAX_CODE_LEN = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire lpcd_pkg::cmd_t                head_cmd,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [lpcd_pkg::CHAR_W-1:0]        out_tdata,
  output logic                               out_tuser
);

  localparam int ADDR_W = lpcd_pkg::LEN_W + MAX_CODE_LEN;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CHW    = lpcd_pkg::CHAR_W;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_kind_r;
  logic              s1_hit_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r;
  logic [CHW-1:0]    out_char_r;
  logic              s1_move;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] addr;
  logic [CHW-1:0]    rdata;

  assign s1_move = s1_valid_r && (!out_valid_r || out_tready);
  assign pop     = head_valid && (!s1_valid_r || s1_move);
  assign ram_we  = pop && head_cmd.op == lpcd_pkg::OP_WRITE;
  assign ram_re  = pop && head_cmd.op == lpcd_pkg::OP_LOOKUP;
  assign addr    = {head_cmd.len, head_cmd.code[MAX_CODE_LEN-1:0]};

  lpcd_ram #(
    .WIDTH (CHW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (head_cmd.data),
    .re    (ram_re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    if (pop) begin
      s1_valid_nxt = (head_cmd.op != lpcd_pkg::OP_WRITE);
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind_r <= (head_cmd.op == lpcd_pkg::OP_EOM) ? lpcd_pkg::KIND_EOM
                                                      : lpcd_pkg::KIND_CHAR;
      s1_hit_r  <= head_cmd.hit;
    end
    if (s1_move) begin
      out_kind_r <= s1_kind_r;
      // unwritten slots and end of message read as zero
      out_char_r <= s1_hit_r ? rdata : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_kind_r;

endmodule

`default_nettype wire

// ----- rtl/lpcd_checker.sv -----
// ----------------------------------------------------------------------------
// lpcd_checker
// Port-level checks for the length-prefixed code decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // reset empties the output stage
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // end of message carries a zero character
  a_eom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0)
    else $error("end of message with nonzero character");

  // input side backs up only behind a stalled output
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

endmodule

bind length_prefixed_code_decoder lpcd_checker u_lpcd_checker (.*);

`default_nettype wire
